@@ design/bcc_pkg.sv @@
// bcc_pkg: shared widths, state and result types, register indexes and reset
// values for the button click classifier
// depends on nothing
package bcc_pkg;

    localparam int TIME_W      = 32;
    localparam int HOLD_W      = 16;
    localparam int BUTTON_W    = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int NUM_BUTTONS_DEF = 2;

    localparam logic [CFG_DATA_W-1:0] DCW_RESET = CFG_DATA_W'(300);
    localparam logic [CFG_DATA_W-1:0] LPT_RESET = CFG_DATA_W'(1000);
    localparam logic [HOLD_W-1:0]     HOLD_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOUBLE_CLICK_WINDOW = 1'b0,
        CFG_LONG_PRESS_TIME     = 1'b1
    } cfg_idx_t;

    // per-button state, all zero after reset
    typedef struct packed {
        logic              is_held;
        logic              release_recorded;
        logic [TIME_W-1:0] press_start_time;
        logic [TIME_W-1:0] release_time;
        logic [HOLD_W-1:0] hold_counter;
    } btn_state_t;

    typedef struct packed {
        logic              single_click;
        logic              double_click;
        logic [HOLD_W-1:0] hold_ticks;
    } click_result_t;

endpackage

@@ design/bcc_in_if.sv @@
// bcc_in_if: valid/ready channel for poll transactions
// depends on bcc_pkg
interface bcc_in_if;
    logic                         valid;
    logic                         ready;
    logic [bcc_pkg::BUTTON_W-1:0] button;
    logic                         pressed;
    logic [bcc_pkg::TIME_W-1:0]   now;

    modport source (output valid, output button, output pressed, output now, input ready);
    modport sink   (input valid, input button, input pressed, input now, output ready);
endinterface

@@ design/bcc_out_if.sv @@
// bcc_out_if: valid/ready channel for click result transactions
// depends on bcc_pkg
interface bcc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       single_click;
    logic                       double_click;
    logic [bcc_pkg::HOLD_W-1:0] hold_ticks;

    modport source (output valid, output single_click, output double_click,
                    output hold_ticks, input ready);
    modport sink   (input valid, input single_click, input double_click,
                    input hold_ticks, output ready);
endinterface

@@ design/button_click_classifier_unit.sv @@
// button_click_classifier_unit: top level of the button click classifier
// depends on bcc_pkg, bcc_in_if, bcc_out_if, bcc_state_mem, bcc_classify
//
// result path: the accepted poll and its state read are registered in stage 1, then in the result register
// throughput: one poll per cycle while the receiver takes results; the store bypass covers same-button polls
// reset: async active-low rst_n clears the pipeline, per-button valid bits and
//   restores the register defaults (window 300, long press 1000); no clearing pass
module button_click_classifier_unit #(
    parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    bcc_in_if.sink                         in_ch,
    bcc_out_if.source                      out_ch
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // configuration registers
    logic [bcc_pkg::CFG_DATA_W-1:0] dcw_reg;
    logic [bcc_pkg::CFG_DATA_W-1:0] lpt_reg;

    // stage 1: accepted poll, state read in flight alongside it
    logic                       s1_valid_reg;
    logic                       s1_pressed_reg;
    logic [bcc_pkg::TIME_W-1:0] s1_now_reg;
    logic [IDX_W-1:0]           s1_addr_reg;
    logic                       s1_inrange_reg;

    // result register
    logic                   out_valid_reg;
    bcc_pkg::click_result_t out_res_reg;

    logic                   in_fire;
    logic                   in_range;
    logic                   s1_adv;
    logic [IDX_W-1:0]       rd_addr;
    bcc_pkg::btn_state_t    cur_state;
    bcc_pkg::btn_state_t    nxt_state;
    bcc_pkg::click_result_t calc_res;
    bcc_pkg::click_result_t s1_res;

    // stage 1 moves on whenever the result register is free or being drained
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_fire     = in_ch.valid && in_ch.ready;
    // buttons past the configured count leave state alone and report zeros
    assign in_range    = int'(in_ch.button) < NUM_BUTTONS;
    assign rd_addr     = IDX_W'(in_ch.button);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcw_reg <= bcc_pkg::DCW_RESET;
            lpt_reg <= bcc_pkg::LPT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (bcc_pkg::cfg_idx_t'(cfg_idx))
                bcc_pkg::CFG_DOUBLE_CLICK_WINDOW: dcw_reg <= cfg_wdata;
                bcc_pkg::CFG_LONG_PRESS_TIME:     lpt_reg <= cfg_wdata;
                default:                          ;
            endcase
        end
    end

    // state store: read issued at accept, written back when stage 1 retires;
    // same-button back-to-back polls are covered by the store's bypass
    bcc_state_mem #(
        .DEPTH (NUM_BUTTONS),
        .IDX_W (IDX_W)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire && in_range),
        .rd_addr (rd_addr),
        .rd_data (cur_state),
        .wr_en   (s1_adv && s1_inrange_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (nxt_state)
    );

    bcc_classify u_classify (
        .cur                 (cur_state),
        .pressed             (s1_pressed_reg),
        .now                 (s1_now_reg),
        .double_click_window (dcw_reg),
        .long_press_time     (lpt_reg),
        .nxt                 (nxt_state),
        .res                 (calc_res)
    );

    assign s1_res = s1_inrange_reg ? calc_res : '0;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pressed_reg <= in_ch.pressed;
            s1_now_reg     <= in_ch.now;
            s1_addr_reg    <= rd_addr;
            s1_inrange_reg <= in_range;
        end
        if (s1_adv)
        begin
            out_res_reg <= s1_res;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.single_click = out_res_reg.single_click;
    assign out_ch.double_click = out_res_reg.double_click;
    assign out_ch.hold_ticks   = out_res_reg.hold_ticks;

`ifndef ASSERT_OFF
    // a double click is always also a new press
    a_double_has_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.double_click |-> out_res_reg.single_click)
        else $error("double click without single click");

    // a fresh press starts from a cleared counter, so it can have advanced once at most
    a_press_hold_small: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.single_click |-> (out_res_reg.hold_ticks <= 16'd1))
        else $error("hold counter too large on a new press");

    // a stalled poll keeps its place in stage 1
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_now_reg)
                                    && $stable(s1_addr_reg))
        else $error("stage 1 transaction lost during stall");

    // an empty stage 1 always takes a new transaction
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty stage 1");
`endif

endmodule

@@ design/bcc_state_mem.sv @@
// bcc_state_mem: per-button state store with valid bits and write bypass
// depends on bcc_pkg
module bcc_state_mem #(
    parameter int DEPTH = bcc_pkg::NUM_BUTTONS_DEF,
    parameter int IDX_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output bcc_pkg::btn_state_t rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  bcc_pkg::btn_state_t wr_data
);

    bcc_pkg::btn_state_t mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    bcc_pkg::btn_state_t rd_data_reg;

    // entries not yet written read as the reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/bcc_classify.sv @@
// bcc_classify: next-state and result logic for one poll of one button
// depends on bcc_pkg
module bcc_classify (
    input  bcc_pkg::btn_state_t            cur,
    input  logic                           pressed,
    input  logic [bcc_pkg::TIME_W-1:0]     now,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] double_click_window,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] long_press_time,
    output bcc_pkg::btn_state_t            nxt,
    output bcc_pkg::click_result_t         res
);

    logic                       press;
    logic                       release_ev;
    logic [bcc_pkg::TIME_W-1:0] since_release;
    logic [bcc_pkg::TIME_W-1:0] since_press;
    logic [bcc_pkg::TIME_W-1:0] start_time;
    logic [bcc_pkg::HOLD_W-1:0] cnt_base;
    logic                       advance;

    always_comb
    begin
        press         = pressed && !cur.is_held;
        release_ev    = !pressed && cur.is_held;
        since_release = now - cur.release_time;
        start_time    = press ? now : cur.press_start_time;
        since_press   = now - start_time;
        cnt_base      = release_ev ? '0 : cur.hold_counter;
        // held after this poll exactly when the level is pressed
        advance       = pressed && (since_press >= long_press_time)
                        && (cnt_base != bcc_pkg::HOLD_MAX);

        nxt                  = cur;
        nxt.is_held          = pressed;
        nxt.press_start_time = start_time;
        nxt.hold_counter     = advance ? cnt_base + 1'b1 : cnt_base;
        if (press)
        begin
            nxt.release_recorded = 1'b0;
        end
        if (release_ev)
        begin
            nxt.release_time     = now;
            nxt.release_recorded = 1'b1;
        end

        res.single_click = press;
        res.double_click = press && cur.release_recorded
                           && (since_release < double_click_window);
        res.hold_ticks   = nxt.hold_counter;
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for button_click_classifier_unit, with a click
// scoreboard that predicts every poll result plus tasks that drive polls and settings
// depends on bcc_pkg, bcc_in_if, bcc_out_if and the design under test
module testbench;
    import bcc_pkg::*;

    localparam int BUTTONS = NUM_BUTTONS_DEF;
    // a little more than the poll-to-result latency
    localparam int SETTLE_CYCLES = 6;
    // receiver hold-off long enough to back the pipeline up into the input
    localparam int LONG_STALL_CYCLES = 300;

    // predicts click results per poll and checks them in order of arrival
    class click_scoreboard;
        logic [TIME_W-1:0] window_ticks;
        logic [TIME_W-1:0] long_press_ticks;
        logic              held[BUTTONS];
        logic              release_seen[BUTTONS];
        logic [TIME_W-1:0] press_at[BUTTONS];
        logic [TIME_W-1:0] release_at[BUTTONS];
        logic [HOLD_W-1:0] hold_count[BUTTONS];
        click_result_t     pending_clicks[$];
        int                errors;
        int                polls_checked;
        int                singles_seen;
        int                doubles_seen;
        int                hold_peak;

        function new();
            window_ticks     = DCW_RESET;
            long_press_ticks = LPT_RESET;
            for (int k = 0; k < BUTTONS; k++)
            begin
                held[k]         = 1'b0;
                release_seen[k] = 1'b0;
                press_at[k]     = '0;
                release_at[k]   = '0;
                hold_count[k]   = '0;
            end
            errors        = 0;
            polls_checked = 0;
            singles_seen  = 0;
            doubles_seen  = 0;
            hold_peak     = 0;
        endfunction

        function void configure(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_DOUBLE_CLICK_WINDOW: window_ticks     = value;
                CFG_LONG_PRESS_TIME:     long_press_ticks = value;
                default: ;
            endcase
        endfunction

        // advance one button's state for an accepted poll and queue the result
        function void note_poll(logic [BUTTON_W-1:0] btn, logic lvl, logic [TIME_W-1:0] now);
            click_result_t     r;
            int                i;
            logic [TIME_W-1:0] since_release;
            logic [TIME_W-1:0] since_press;
            r = '0;
            i = btn;
            if (i >= BUTTONS)
            begin
                pending_clicks.push_back(r);
                return;
            end
            if (lvl && !held[i])
            begin
                press_at[i]    = now;
                held[i]        = 1'b1;
                r.single_click = 1'b1;
                since_release  = now - release_at[i];
                if (release_seen[i] && since_release < window_ticks)
                    r.double_click = 1'b1;
                // a press always uses up the recorded release
                release_seen[i] = 1'b0;
            end
            if (!lvl && held[i])
            begin
                release_at[i]   = now;
                release_seen[i] = 1'b1;
                held[i]         = 1'b0;
                hold_count[i]   = '0;
            end
            since_press = now - press_at[i];
            if (held[i] && since_press >= long_press_ticks && hold_count[i] != HOLD_MAX)
                hold_count[i] = hold_count[i] + 1'b1;
            r.hold_ticks = hold_count[i];
            pending_clicks.push_back(r);
        endfunction

        function void check_result(click_result_t got);
            click_result_t exp;
            if (pending_clicks.size() == 0)
            begin
                $error("result with no poll outstanding: single %0d double %0d hold %0d",
                       got.single_click, got.double_click, got.hold_ticks);
                errors++;
                return;
            end
            exp = pending_clicks.pop_front();
            polls_checked++;
            if (got.single_click !== exp.single_click)
            begin
                $error("single_click: expected %0d, actual %0d", exp.single_click,
                       got.single_click);
                errors++;
            end
            if (got.double_click !== exp.double_click)
            begin
                $error("double_click: expected %0d, actual %0d", exp.double_click,
                       got.double_click);
                errors++;
            end
            if (got.hold_ticks !== exp.hold_ticks)
            begin
                $error("hold_ticks: expected %0d, actual %0d", exp.hold_ticks, got.hold_ticks);
                errors++;
            end
            if (exp.single_click)
                singles_seen++;
            if (exp.double_click)
                doubles_seen++;
            if (int'(exp.hold_ticks) > hold_peak)
                hold_peak = exp.hold_ticks;
        endfunction

        function int outstanding();
            return pending_clicks.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bcc_in_if  in_ch();
    bcc_out_if out_ch();

    click_scoreboard sb = new();

    // stimulus-side view of each button, so random sequences stay well formed
    logic              gen_level[BUTTONS];
    logic [TIME_W-1:0] gen_time[BUTTONS];
    logic [TIME_W-1:0] gen_press_at[BUTTONS];
    logic [TIME_W-1:0] gen_release_at[BUTTONS];
    logic [TIME_W-1:0] cur_window;
    logic [TIME_W-1:0] cur_hold_time;

    int burst_left;
    int settings_used;
    bit long_stall_req;

    button_click_classifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #5 clk = ~clk;

    // hard stop in case the handshakes hang
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: ready follows a pattern that steps through four modes in turn;
    // a long hold-off can be requested to back the block up into its input
    initial
    begin
        int cyc;
        int mode;
        int stall_count;
        cyc = 0;
        stall_count = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            mode = (cyc / 97) % 4;
            if (long_stall_req && stall_count < LONG_STALL_CYCLES)
            begin
                out_ch.ready <= 1'b0;
                stall_count++;
            end
            else
            begin
                if (long_stall_req)
                begin
                    long_stall_req = 1'b0;
                    stall_count = 0;
                end
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ((cyc % 3) != 0);
                    default: out_ch.ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // every result transaction goes straight to the scoreboard
    always @(posedge clk)
    begin
        click_result_t got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.single_click = out_ch.single_click;
            got.double_click = out_ch.double_click;
            got.hold_ticks   = out_ch.hold_ticks;
            sb.check_result(got);
        end
    end

    // offer one poll transaction; the sender works in bursts with gaps between
    task automatic offer_poll(input logic [BUTTON_W-1:0] btn, input logic lvl,
                              input logic [TIME_W-1:0] now);
        if (burst_left == 0)
        begin
            // about one burst in five runs straight on without a gap
            if ($urandom_range(0, 4) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.button  <= btn;
        in_ch.pressed <= lvl;
        in_ch.now     <= now;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_poll(btn, lvl, now);
    endtask

    // offer a poll and keep the stimulus-side button view up to date
    task automatic poll_button(input logic [BUTTON_W-1:0] btn, input logic lvl,
                               input logic [TIME_W-1:0] now);
        int i;
        i = btn;
        if (lvl && !gen_level[i])
            gen_press_at[i] = now;
        if (!lvl && gen_level[i])
            gen_release_at[i] = now;
        gen_level[i] = lvl;
        gen_time[i]  = now;
        offer_poll(btn, lvl, now);
    endtask

    // drop valid and let every expected result come back before touching settings
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.configure(idx, value);
    endtask

    task automatic set_timing(input logic [TIME_W-1:0] window,
                              input logic [TIME_W-1:0] hold_time);
        drain_block();
        write_reg(CFG_DOUBLE_CLICK_WINDOW, window);
        write_reg(CFG_LONG_PRESS_TIME, hold_time);
        cur_window    = window;
        cur_hold_time = hold_time;
        settings_used++;
    endtask

    // time step between polls, scaled to the current window and hold time
    function automatic logic [TIME_W-1:0] pace_ticks();
        logic [TIME_W-1:0] span;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 4);
            1: span = cur_window;
            2: span = cur_hold_time;
            default: return $urandom_range(0, 50);
        endcase
        if (span > 4000)
            span = 4000;
        return $urandom_range(0, 2 * span + 1);
    endfunction

    // mostly press/hold/release sequences with moving time, some pure noise
    task automatic run_random_polls(input int count);
        logic [BUTTON_W-1:0] btn;
        logic                lvl;
        logic [TIME_W-1:0]   now;
        int                  i;
        for (int k = 0; k < count; k++)
        begin
            btn = $urandom_range(0, BUTTONS - 1);
            i = btn;
            if ($urandom_range(0, 99) < 12)
            begin
                lvl = $urandom_range(0, 1);
                now = $urandom;
            end
            else
            begin
                lvl = gen_level[i];
                if ($urandom_range(0, 99) < 35)
                    lvl = !lvl;
                now = gen_time[i] + pace_ticks();
                // aim some presses and held polls right at the window and hold edges
                if (lvl && !gen_level[i] && $urandom_range(0, 3) == 0)
                    now = gen_release_at[i] + cur_window + $urandom_range(0, 2) - 1;
                else if (lvl && gen_level[i] && $urandom_range(0, 7) == 0)
                    now = gen_press_at[i] + cur_hold_time + $urandom_range(0, 2) - 1;
            end
            poll_button(btn, lvl, now);
        end
    endtask

    initial
    begin
        int guard;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_DOUBLE_CLICK_WINDOW;
        cfg_wdata     <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.button  <= '0;
        in_ch.pressed <= 1'b0;
        in_ch.now     <= '0;
        for (int k = 0; k < BUTTONS; k++)
        begin
            gen_level[k]      = 1'b0;
            gen_time[k]       = '0;
            gen_press_at[k]   = '0;
            gen_release_at[k] = '0;
        end
        cur_window     = DCW_RESET;
        cur_hold_time  = LPT_RESET;
        burst_left     = 0;
        settings_used  = 1;
        long_stall_req = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset timing, window 300 and long press 1000
        poll_button(0, 1'b1, 32'd100);        // first press, no release yet
        poll_button(0, 1'b1, 32'd1099);       // one tick short of long press
        poll_button(0, 1'b1, 32'd1100);       // long press reached
        poll_button(0, 1'b1, 32'd1101);
        poll_button(0, 1'b0, 32'd1200);       // release clears the counter
        poll_button(0, 1'b1, 32'd1499);       // last tick inside the window
        poll_button(0, 1'b0, 32'd1500);
        poll_button(0, 1'b1, 32'd1800);       // exactly the window, no double
        poll_button(0, 1'b0, 32'd1810);
        poll_button(0, 1'b1, 32'd1820);       // double click
        poll_button(0, 1'b1, 32'd1825);       // still held, release was used up
        poll_button(0, 1'b0, 32'd1830);
        poll_button(0, 1'b0, 32'd1835);       // released and idle
        poll_button(1, 1'b1, 32'hFFFF_FFF0);  // press just before time wraps
        poll_button(1, 1'b0, 32'hFFFF_FFF8);
        poll_button(1, 1'b1, 32'h0000_0020);  // double click across the wrap
        poll_button(1, 1'b1, 32'h0000_03FF);  // 991 ticks held
        poll_button(1, 1'b1, 32'h0000_0408);  // 1000 ticks held
        poll_button(1, 1'b1, 32'hFFFF_FFFF);
        poll_button(1, 1'b0, 32'h0000_0000);
        poll_button(0, 1'b1, 32'h0000_0000);

        // random phases across the timing extremes
        run_random_polls(120);

        set_timing(32'd0, 32'd0);             // doubles impossible, counting at once
        poll_button(1, 1'b1, 32'd5000);       // counts on the press poll itself
        poll_button(1, 1'b0, 32'd5001);
        poll_button(1, 1'b1, 32'd5001);       // zero ticks since release, still no double
        run_random_polls(110);

        set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random_polls(110);

        set_timing($urandom_range(1, 2000), $urandom_range(0, 3000));
        run_random_polls(60);
        // receiver holds off while polls keep coming, so the block fills up
        long_stall_req = 1'b1;
        run_random_polls(60);
        run_random_polls(60);

        set_timing(32'd5, 32'd20);
        run_random_polls(120);

        in_ch.valid <= 1'b0;
        guard = 0;
        while (sb.outstanding() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            $error("%0d expected results never arrived", sb.outstanding());
            sb.errors++;
        end

        $display("checked %0d poll results under %0d timing settings", sb.polls_checked,
                 settings_used);
        $display("saw %0d single and %0d double clicks, hold counter peaked at %0d",
                 sb.singles_seen, sb.doubles_seen, sb.hold_peak);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
